// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files; included by the scheduler top level.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/pps_pkg.sv =====
// Package for the preemptive priority scheduler: widths, slot record, codes,
// compare and saturating-add helpers. No dependencies.
package pps_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int ID_W      = 8;
    localparam int LEFT_W    = 16;
    localparam int PRIO_W    = 8;
    localparam int TIME_W    = 32;
    localparam int DONE_W    = 16;

    localparam logic OP_ADMIT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // admit status: taken, or dropped on a full ready table
    localparam logic ST_ACCEPTED = 1'b0;
    localparam logic ST_FULL     = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEFT_W-1:0] left;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] arrival;
        logic              started;
        logic [TIME_W-1:0] age;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    // a beats b: lower prio, then less remaining burst, then older
    function automatic logic slot_better(input t_slot a, input t_slot b);
        logic res;
        if (a.prio != b.prio) begin
            res = (a.prio < b.prio);
        end else if (a.left != b.left) begin
            res = (a.left < b.left);
        end else begin
            res = (a.age < b.age);
        end
        return res;
    endfunction

    function automatic logic [TIME_W-1:0] sat_add32(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/pps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on pps_pkg for parameter defaults only.
module pps_ram #(
    parameter int WIDTH = pps_pkg::SLOT_W,
    parameter int DEPTH = pps_pkg::SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler top level: ready table, sequencer, statistics.
// Depends on pps_pkg, pps_ram and assert_macros.svh.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  input    | i_in_valid / o_in_ready    | i_op, i_task_id, i_burst, i_prio
//  result   | o_res_valid / i_res_ready  | o_status, o_run_*, o_done_*, o_sum_*,
//           |                            | o_done_count, o_now
//
// Sequencing: an admit word probes for the lowest free slot, one slot per
// cycle; a tick word runs the best-task scan that reads one ready-table entry
// per cycle from the slot RAM into one comparator.
// Reset: i_rst_n synchronous, active low; clears slot valid bits, the running
// task, time, sums and the sequencer. The slot RAM itself is never cleared.
// Stalls: o_in_ready is high only while the sequencer idles; a result waits in
// the output register and the next word is taken meanwhile. A finished word
// holds in the emit step until the output register is free.
module preemptive_priority_scheduler #(
    parameter int SLOTS = pps_pkg::SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_op,
    input  logic [pps_pkg::ID_W-1:0]  i_task_id,
    input  logic [pps_pkg::LEFT_W-1:0] i_burst,
    input  logic [pps_pkg::PRIO_W-1:0] i_prio,
    // result channel
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output logic                      o_status,
    output logic                      o_run_valid,
    output logic [pps_pkg::ID_W-1:0]  o_run_id,
    output logic                      o_done_valid,
    output logic [pps_pkg::ID_W-1:0]  o_done_id,
    output logic [pps_pkg::TIME_W-1:0] o_sum_waiting,
    output logic [pps_pkg::TIME_W-1:0] o_sum_response,
    output logic [pps_pkg::TIME_W-1:0] o_sum_turnaround,
    output logic [pps_pkg::DONE_W-1:0] o_done_count,
    output logic [pps_pkg::TIME_W-1:0] o_now
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ASCAN  = 4'd1;  // probe for lowest free slot
    localparam logic [3:0] S_DONE   = 4'd2;  // check running task for completion
    localparam logic [3:0] S_DADD   = 4'd3;  // retire it, add turnaround
    localparam logic [3:0] S_SCAN   = 4'd4;  // issue slot reads
    localparam logic [3:0] S_DRAIN  = 4'd5;  // compare last read
    localparam logic [3:0] S_COMMIT = 4'd6;  // dispatch or preempt
    localparam logic [3:0] S_RUN    = 4'd7;  // run one unit, waiting sum
    localparam logic [3:0] S_RESP   = 4'd8;  // response sum
    localparam logic [3:0] S_EMIT   = 4'd9;  // load output register

    logic [3:0]                  r_state;
    logic [SLOTS-1:0]            r_used;
    logic [CW-1:0]               r_count;
    logic [IW-1:0]               r_idx;
    logic [IW-1:0]               r_pidx;
    logic                        r_pv;
    logic                        r_found;
    logic [IW-1:0]               r_best_idx;
    pps_pkg::t_slot              r_best;
    pps_pkg::t_slot              r_cur;
    logic                        r_cur_busy;
    logic [pps_pkg::TIME_W-1:0]  r_now;
    logic [pps_pkg::TIME_W-1:0]  r_seq;
    logic [pps_pkg::TIME_W-1:0]  r_acc_waiting;
    logic [pps_pkg::TIME_W-1:0]  r_acc_response;
    logic [pps_pkg::TIME_W-1:0]  r_acc_turnaround;
    logic [pps_pkg::DONE_W-1:0]  r_acc_done;

    // captured word and per-word results
    logic                        r_op;
    logic [pps_pkg::ID_W-1:0]    r_in_id;
    logic [pps_pkg::LEFT_W-1:0]  r_in_burst;
    logic [pps_pkg::PRIO_W-1:0]  r_in_prio;
    logic                        r_res_status;
    logic                        r_res_run_valid;
    logic [pps_pkg::ID_W-1:0]    r_res_run_id;
    logic                        r_res_done_valid;
    logic [pps_pkg::ID_W-1:0]    r_res_done_id;
    logic [pps_pkg::TIME_W-1:0]  r_diff;
    logic                        r_resp_pend;

    // output register
    logic                        r_o_valid;
    logic                        r_o_status;
    logic                        r_o_run_valid;
    logic [pps_pkg::ID_W-1:0]    r_o_run_id;
    logic                        r_o_done_valid;
    logic [pps_pkg::ID_W-1:0]    r_o_done_id;
    logic [pps_pkg::TIME_W-1:0]  r_o_sum_waiting;
    logic [pps_pkg::TIME_W-1:0]  r_o_sum_response;
    logic [pps_pkg::TIME_W-1:0]  r_o_sum_turnaround;
    logic [pps_pkg::DONE_W-1:0]  r_o_done_count;
    logic [pps_pkg::TIME_W-1:0]  r_o_now;

    // slot RAM ports
    logic                        w_we;
    logic [IW-1:0]               w_waddr;
    pps_pkg::t_slot              w_wdata;
    pps_pkg::t_slot              w_rd;
    pps_pkg::t_slot              w_admit_rec;
    logic                        w_take;
    logic                        w_out_free;
    logic                        w_last;
    logic                        w_emit;
    logic                        w_dispatch;

    pps_ram #(
        .WIDTH (pps_pkg::SLOT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rd)
    );

    assign w_last     = (r_idx == LAST_IDX);
    assign w_out_free = !r_o_valid || i_res_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_emit     = (r_state == S_EMIT) && w_out_free;

    // dispatch when idle; preempt on a more urgent task or same prio and shorter rest
    assign w_take = r_found &&
                    (!r_cur_busy ||
                     (r_best.prio < r_cur.prio) ||
                     ((r_best.prio == r_cur.prio) && (r_best.left < r_cur.left)));

    // dispatch onto an idle processor: the chosen slot is released
    assign w_dispatch = (r_state == S_COMMIT) && w_take && !r_cur_busy;

    always_comb begin
        w_admit_rec.id      = r_in_id;
        w_admit_rec.left    = r_in_burst;
        w_admit_rec.prio    = r_in_prio;
        w_admit_rec.arrival = r_now;
        w_admit_rec.started = 1'b0;
        w_admit_rec.age     = r_seq;
    end

    // Write the admitted task into the free slot, or park the preempted task
    // in the slot its successor leaves.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_admit_rec;
        if (r_state == S_ASCAN && !r_used[r_idx]) begin
            w_we = 1'b1;
        end else if (r_state == S_COMMIT && w_take && r_cur_busy) begin
            w_we    = 1'b1;
            w_waddr = r_best_idx;
            w_wdata = r_cur;
        end
    end

    // control, task state and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_used           <= '0;
            r_count          <= '0;
            r_idx            <= '0;
            r_pv             <= 1'b0;
            r_found          <= 1'b0;
            r_best_idx       <= '0;
            r_best           <= '0;
            r_cur            <= '0;
            r_cur_busy       <= 1'b0;
            r_now            <= '0;
            r_seq            <= '0;
            r_acc_waiting    <= '0;
            r_acc_response   <= '0;
            r_acc_turnaround <= '0;
            r_acc_done       <= '0;
            r_o_valid        <= 1'b0;
        end else begin
            // read data of a scan slot arrives in the cycle after its address
            r_pv <= (r_state == S_SCAN);
            // load on emit, drop once the receiver takes the word
            r_o_valid <= w_emit || (r_o_valid && !i_res_ready);

            // one comparator, one slot per cycle, in the cycle after the read
            if (r_pv && r_used[r_pidx] &&
                (!r_found || pps_pkg::slot_better(w_rd, r_best))) begin
                r_found    <= 1'b1;
                r_best_idx <= r_pidx;
                r_best     <= w_rd;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_idx   <= '0;
                        r_state <= (i_op == pps_pkg::OP_TICK) ? S_DONE : S_ASCAN;
                    end
                end
                S_ASCAN: begin
                    if (!r_used[r_idx]) begin
                        r_used[r_idx] <= 1'b1;
                        r_count       <= r_count + CW'(1);
                        r_seq         <= r_seq + 32'd1;
                        r_state       <= S_EMIT;
                    end else if (w_last) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_DONE: begin
                    r_state <= S_DADD;
                end
                S_DADD: begin
                    if (r_res_done_valid) begin
                        r_acc_turnaround <= pps_pkg::sat_add32(r_acc_turnaround, r_diff);
                        if (r_acc_done != {pps_pkg::DONE_W{1'b1}}) begin
                            r_acc_done <= r_acc_done + 16'd1;
                        end
                        r_cur_busy <= 1'b0;
                    end
                    r_found <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (w_take) begin
                        r_cur      <= r_best;
                        r_cur_busy <= 1'b1;
                        if (!r_cur_busy) begin
                            r_used[r_best_idx] <= 1'b0;
                            r_count            <= r_count - CW'(1);
                        end
                    end
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (r_cur_busy) begin
                        if (r_cur.left != '0) begin
                            r_cur.left <= r_cur.left - 16'd1;
                        end
                        r_cur.started <= 1'b1;
                    end
                    r_acc_waiting <= pps_pkg::sat_add32(r_acc_waiting, 32'(r_count));
                    r_state       <= S_RESP;
                end
                S_RESP: begin
                    if (r_resp_pend) begin
                        r_acc_response <= pps_pkg::sat_add32(r_acc_response, r_diff);
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        if (r_op == pps_pkg::OP_TICK) begin
                            r_now <= r_now + 32'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // captured word, per-word results, output payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_op             <= i_op;
                    r_in_id          <= i_task_id;
                    r_in_burst       <= i_burst;
                    r_in_prio        <= i_prio;
                    r_res_status     <= pps_pkg::ST_ACCEPTED;
                    r_res_run_valid  <= 1'b0;
                    r_res_run_id     <= '0;
                    r_res_done_valid <= 1'b0;
                    r_res_done_id    <= '0;
                end
            end
            S_ASCAN: begin
                if (r_used[r_idx] && w_last) begin
                    r_res_status <= pps_pkg::ST_FULL;
                end
            end
            S_DONE: begin
                r_res_done_valid <= r_cur_busy && (r_cur.left == '0);
                r_res_done_id    <= (r_cur_busy && (r_cur.left == '0)) ? r_cur.id : '0;
                r_diff           <= r_now - r_cur.arrival;
            end
            S_SCAN: begin
                r_pidx <= r_idx;
            end
            S_RUN: begin
                r_res_run_valid <= r_cur_busy;
                r_res_run_id    <= r_cur_busy ? r_cur.id : '0;
                r_resp_pend     <= r_cur_busy && !r_cur.started;
                r_diff          <= r_now - r_cur.arrival;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    r_o_status         <= r_res_status;
                    r_o_run_valid      <= r_res_run_valid;
                    r_o_run_id         <= r_res_run_id;
                    r_o_done_valid     <= r_res_done_valid;
                    r_o_done_id        <= r_res_done_id;
                    r_o_sum_waiting    <= r_acc_waiting;
                    r_o_sum_response   <= r_acc_response;
                    r_o_sum_turnaround <= r_acc_turnaround;
                    r_o_done_count     <= r_acc_done;
                    r_o_now            <= r_now;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res_valid      = r_o_valid;
    assign o_status         = r_o_status;
    assign o_run_valid      = r_o_run_valid;
    assign o_run_id         = r_o_run_id;
    assign o_done_valid     = r_o_done_valid;
    assign o_done_id        = r_o_done_id;
    assign o_sum_waiting    = r_o_sum_waiting;
    assign o_sum_response   = r_o_sum_response;
    assign o_sum_turnaround = r_o_sum_turnaround;
    assign o_done_count     = r_o_done_count;
    assign o_now            = r_o_now;

`include "assert_macros.svh"

    // occupancy counter tracks the slot valid bits
    `ASSERT_IMPL(a_count_match, i_clk, i_rst_n, 1'b1, 32'(r_count) == $countones(r_used))
    // a dispatch onto an idle processor frees exactly one slot
    `ASSERT_NEXT(a_dispatch_frees, i_clk, i_rst_n, w_dispatch, r_count == $past(r_count) - CW'(1))
    // the completion count never goes backward
    `ASSERT_NEXT(a_done_mono, i_clk, i_rst_n, r_state != S_IDLE, r_acc_done >= $past(r_acc_done))
    // a free output register takes the result and the sequencer returns to idle
    `ASSERT_NEXT(a_emit_loads, i_clk, i_rst_n, w_emit, r_o_valid && r_state == S_IDLE)

endmodule
